// ----- rtl/core/bhsq_pkg.sv -----
// Package: shared constants, types and register codes of the sensor qualifier.
package bhsq_pkg;

  localparam int SAMPLE_BITS         = 10;
  localparam int SAMPLES_PER_AVERAGE = 5;

  // Block sums and the counter that walks one block.
  localparam int SUM_W = SAMPLE_BITS + $clog2(SAMPLES_PER_AVERAGE);
  localparam int CNT_W = $clog2(SAMPLES_PER_AVERAGE + 1);

  // Truncated average through a reciprocal; exact for every sum below 2**SUM_W.
  localparam int RECIP_SHIFT = SUM_W + $clog2(SAMPLES_PER_AVERAGE) + 1;
  localparam int RECIP_W     = RECIP_SHIFT + 1;
  localparam int RECIP_MUL   = ((2 ** RECIP_SHIFT) + SAMPLES_PER_AVERAGE - 1)
                               / SAMPLES_PER_AVERAGE;
  localparam int AVG_PROD_W  = SUM_W + RECIP_W;

  // Threshold compares: avg*100 against baseline*pct.
  localparam int PCT_W     = 8;
  localparam int PCT_SCALE = 100;
  localparam int PROD_W    = SAMPLE_BITS + PCT_W;

  // Duty: (light-100)*100/900 reduces to (light-100)/9, by reciprocal.
  localparam int DUTY_W       = 7;
  localparam int LIGHT_FLOOR  = 100;
  localparam int FULL_SCALE   = 1000;
  localparam int DUTY_DIV     = (FULL_SCALE - LIGHT_FLOOR) / PCT_SCALE;
  localparam int DUTY_SHIFT   = SAMPLE_BITS + 4;
  localparam int DUTY_MUL     = ((2 ** DUTY_SHIFT) + DUTY_DIV - 1) / DUTY_DIV;
  localparam int DUTY_PROD_W  = SAMPLE_BITS + DUTY_SHIFT;
  localparam int DUTY_LOW     = 5;
  localparam int DUTY_HIGH    = 95;
  localparam int DUTY_MAX     = 100;

  // Queue between front and back.
  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

  // Configuration port.
  localparam int NUM_REGS   = 6;
  localparam int ADDR_W     = $clog2(NUM_REGS * 4);
  localparam int REG_IDX_W  = ADDR_W - 2;
  localparam int APB_DATA_W = 32;

  localparam logic [PCT_W-1:0] LIGHT_ON_RST      = PCT_W'(180);
  localparam logic [PCT_W-1:0] LIGHT_OFF_RST     = PCT_W'(120);
  localparam logic [PCT_W-1:0] TEMP_ON_RST       = PCT_W'(104);
  localparam logic [PCT_W-1:0] TEMP_OFF_RST      = PCT_W'(101);
  localparam logic [PCT_W-1:0] TOUCH_PRESS_RST   = PCT_W'(70);
  localparam logic [PCT_W-1:0] TOUCH_RELEASE_RST = PCT_W'(90);

  typedef enum logic [REG_IDX_W-1:0] {
    REG_LIGHT_ON      = REG_IDX_W'(0),
    REG_LIGHT_OFF     = REG_IDX_W'(1),
    REG_TEMP_ON       = REG_IDX_W'(2),
    REG_TEMP_OFF      = REG_IDX_W'(3),
    REG_TOUCH_PRESS   = REG_IDX_W'(4),
    REG_TOUCH_RELEASE = REG_IDX_W'(5)
  } cfg_reg_e;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] light;
    logic [SAMPLE_BITS-1:0] touch;
    logic [SAMPLE_BITS-1:0] temp;
  } avg_t;

  typedef struct packed {
    logic [SUM_W-1:0] light;
    logic [SUM_W-1:0] touch;
    logic [SUM_W-1:0] temp;
  } sum_t;

  typedef struct packed {
    logic [PCT_W-1:0] light_on;
    logic [PCT_W-1:0] light_off;
    logic [PCT_W-1:0] temp_on;
    logic [PCT_W-1:0] temp_off;
    logic [PCT_W-1:0] touch_press;
    logic [PCT_W-1:0] touch_release;
  } pct_t;

  typedef struct packed {
    logic [PROD_W-1:0] light_on;
    logic [PROD_W-1:0] light_off;
    logic [PROD_W-1:0] temp_on;
    logic [PROD_W-1:0] temp_off;
    logic [PROD_W-1:0] touch_press;
    logic [PROD_W-1:0] touch_release;
  } lim_t;

  // Push/full handshake from the front into the queue.
  typedef struct packed {
    logic push;
    avg_t data;
  } q_wr_t;

endpackage

// ----- rtl/core/bhsq_if.sv -----
// Interfaces: conversion channel and result channel with valid/ready handshake.
interface bhsq_in_if;
  logic                                valid;
  logic                                ready;
  logic [bhsq_pkg::SAMPLE_BITS-1:0]    light_sample;
  logic [bhsq_pkg::SAMPLE_BITS-1:0]    touch_sample;
  logic [bhsq_pkg::SAMPLE_BITS-1:0]    temp_sample;

  modport source (output valid, light_sample, touch_sample, temp_sample, input ready);
  modport sink   (input valid, light_sample, touch_sample, temp_sample, output ready);
endinterface

interface bhsq_out_if;
  logic                           valid;
  logic                           ready;
  logic                           light_led;
  logic                           temp_led;
  logic                           touch_led;
  logic [bhsq_pkg::DUTY_W-1:0]    duty_percent;

  modport source (output valid, light_led, temp_led, touch_led, duty_percent, input ready);
  modport sink   (input valid, light_led, temp_led, touch_led, duty_percent, output ready);
endinterface

// ----- rtl/core/bhsq_cfg.sv -----
// Threshold register file behind the APB-style write/read port.
module bhsq_cfg (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [bhsq_pkg::ADDR_W-1:0]        paddr,
  input  logic [bhsq_pkg::APB_DATA_W-1:0]    pwdata,
  output logic [bhsq_pkg::APB_DATA_W-1:0]    prdata,
  output logic                               pready,
  output bhsq_pkg::pct_t                     pct_o
);

  bhsq_pkg::pct_t             pct_q, pct_d;
  bhsq_pkg::cfg_reg_e         idx;
  logic                       wr_en;
  logic [bhsq_pkg::PCT_W-1:0] wr_val;
  logic [bhsq_pkg::PCT_W-1:0] rd_val;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;
  assign wr_val = pwdata[bhsq_pkg::PCT_W-1:0];
  assign idx    = bhsq_pkg::cfg_reg_e'(paddr[bhsq_pkg::ADDR_W-1:2]);

  always_comb begin
    pct_d = pct_q;
    if (wr_en) begin
      unique case (idx)
        bhsq_pkg::REG_LIGHT_ON:      pct_d.light_on      = wr_val;
        bhsq_pkg::REG_LIGHT_OFF:     pct_d.light_off     = wr_val;
        bhsq_pkg::REG_TEMP_ON:       pct_d.temp_on       = wr_val;
        bhsq_pkg::REG_TEMP_OFF:      pct_d.temp_off      = wr_val;
        bhsq_pkg::REG_TOUCH_PRESS:   pct_d.touch_press   = wr_val;
        bhsq_pkg::REG_TOUCH_RELEASE: pct_d.touch_release = wr_val;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      bhsq_pkg::REG_LIGHT_ON:      rd_val = pct_q.light_on;
      bhsq_pkg::REG_LIGHT_OFF:     rd_val = pct_q.light_off;
      bhsq_pkg::REG_TEMP_ON:       rd_val = pct_q.temp_on;
      bhsq_pkg::REG_TEMP_OFF:      rd_val = pct_q.temp_off;
      bhsq_pkg::REG_TOUCH_PRESS:   rd_val = pct_q.touch_press;
      bhsq_pkg::REG_TOUCH_RELEASE: rd_val = pct_q.touch_release;
      default:                     rd_val = '0;
    endcase
  end

  assign prdata = bhsq_pkg::APB_DATA_W'(rd_val);
  assign pct_o  = pct_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pct_q.light_on      <= bhsq_pkg::LIGHT_ON_RST;
      pct_q.light_off     <= bhsq_pkg::LIGHT_OFF_RST;
      pct_q.temp_on       <= bhsq_pkg::TEMP_ON_RST;
      pct_q.temp_off      <= bhsq_pkg::TEMP_OFF_RST;
      pct_q.touch_press   <= bhsq_pkg::TOUCH_PRESS_RST;
      pct_q.touch_release <= bhsq_pkg::TOUCH_RELEASE_RST;
    end else begin
      pct_q <= pct_d;
    end
  end

endmodule

// ----- rtl/core/bhsq_front.sv -----
// Front end: accumulate conversions, average each block, capture the baseline.
module bhsq_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  bhsq_in_if.sink              sample_i,
  input  logic                 full_i,
  output bhsq_pkg::q_wr_t      wr_o,
  output bhsq_pkg::avg_t       base_o
);

  localparam logic [bhsq_pkg::CNT_W-1:0] LAST_CNT =
    bhsq_pkg::CNT_W'(bhsq_pkg::SAMPLES_PER_AVERAGE - 1);
  localparam logic [bhsq_pkg::RECIP_W-1:0] RECIP =
    bhsq_pkg::RECIP_W'(bhsq_pkg::RECIP_MUL);

  bhsq_pkg::sum_t              sum_q, sum_d, sum_nxt;
  bhsq_pkg::sum_t              blk_q, blk_d;
  logic [bhsq_pkg::CNT_W-1:0]  cnt_q, cnt_d;
  logic                        blk_valid_q, blk_valid_d;
  logic                        base_valid_q, base_valid_d;
  bhsq_pkg::avg_t              base_q, base_d;
  bhsq_pkg::avg_t              avg;
  logic [bhsq_pkg::AVG_PROD_W-1:0] prod_light, prod_touch, prod_temp;
  logic                        last, blk_take, accept;

  assign last     = (cnt_q == LAST_CNT);
  // A finished block leaves when it becomes the baseline or the queue has room.
  assign blk_take = blk_valid_q && (!base_valid_q || !full_i);
  assign sample_i.ready = !last || !blk_valid_q || blk_take;
  assign accept   = sample_i.valid && sample_i.ready;

  always_comb begin
    sum_nxt.light = sum_q.light + bhsq_pkg::SUM_W'(sample_i.light_sample);
    sum_nxt.touch = sum_q.touch + bhsq_pkg::SUM_W'(sample_i.touch_sample);
    sum_nxt.temp  = sum_q.temp  + bhsq_pkg::SUM_W'(sample_i.temp_sample);
  end

  always_comb begin
    sum_d       = sum_q;
    cnt_d       = cnt_q;
    blk_d       = blk_q;
    blk_valid_d = blk_valid_q && !blk_take;
    if (accept) begin
      if (last) begin
        blk_d       = sum_nxt;
        blk_valid_d = 1'b1;
        sum_d       = '0;
        cnt_d       = '0;
      end else begin
        sum_d = sum_nxt;
        cnt_d = cnt_q + bhsq_pkg::CNT_W'(1);
      end
    end
  end

  always_comb begin
    prod_light = bhsq_pkg::AVG_PROD_W'(blk_q.light) * bhsq_pkg::AVG_PROD_W'(RECIP);
    prod_touch = bhsq_pkg::AVG_PROD_W'(blk_q.touch) * bhsq_pkg::AVG_PROD_W'(RECIP);
    prod_temp  = bhsq_pkg::AVG_PROD_W'(blk_q.temp)  * bhsq_pkg::AVG_PROD_W'(RECIP);
    avg.light  = prod_light[bhsq_pkg::RECIP_SHIFT +: bhsq_pkg::SAMPLE_BITS];
    avg.touch  = prod_touch[bhsq_pkg::RECIP_SHIFT +: bhsq_pkg::SAMPLE_BITS];
    avg.temp   = prod_temp[bhsq_pkg::RECIP_SHIFT +: bhsq_pkg::SAMPLE_BITS];
  end

  always_comb begin
    base_d       = base_q;
    base_valid_d = base_valid_q;
    if (blk_take && !base_valid_q) begin
      base_d       = avg;
      base_valid_d = 1'b1;
    end
  end

  assign wr_o.push = blk_take && base_valid_q;
  assign wr_o.data = avg;
  assign base_o    = base_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q        <= '0;
      cnt_q        <= '0;
      blk_valid_q  <= 1'b0;
      base_valid_q <= 1'b0;
      base_q       <= '0;
    end else begin
      sum_q        <= sum_d;
      cnt_q        <= cnt_d;
      blk_valid_q  <= blk_valid_d;
      base_valid_q <= base_valid_d;
      base_q       <= base_d;
    end
  end

  always_ff @(posedge clk_i) begin
    blk_q <= blk_d;
  end

endmodule

// ----- rtl/core/bhsq_fifo.sv -----
// Short queue of block averages between front and back.
module bhsq_fifo (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  bhsq_pkg::q_wr_t      wr_i,
  output logic                 full_o,
  input  logic                 pop_i,
  output logic                 valid_o,
  output bhsq_pkg::avg_t       data_o
);

  localparam logic [bhsq_pkg::QUEUE_AW-1:0] LAST_PTR =
    bhsq_pkg::QUEUE_AW'(bhsq_pkg::QUEUE_DEPTH - 1);
  localparam logic [bhsq_pkg::QUEUE_CW-1:0] DEPTH =
    bhsq_pkg::QUEUE_CW'(bhsq_pkg::QUEUE_DEPTH);

  bhsq_pkg::avg_t                  mem_q [bhsq_pkg::QUEUE_DEPTH];
  logic [bhsq_pkg::QUEUE_AW-1:0]   wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [bhsq_pkg::QUEUE_CW-1:0]   cnt_q, cnt_d;
  logic                            do_wr, do_rd;

  assign full_o  = (cnt_q == DEPTH);
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign do_wr   = wr_i.push && !full_o;
  assign do_rd   = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_wr) begin
      wr_ptr_d = (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + bhsq_pkg::QUEUE_AW'(1);
    end
    if (do_rd) begin
      rd_ptr_d = (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + bhsq_pkg::QUEUE_AW'(1);
    end
    if (do_wr && !do_rd) begin
      cnt_d = cnt_q + bhsq_pkg::QUEUE_CW'(1);
    end else if (do_rd && !do_wr) begin
      cnt_d = cnt_q - bhsq_pkg::QUEUE_CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_i.data;
    end
  end

endmodule

// ----- rtl/core/bhsq_back.sv -----
// Back end: scale and threshold products, hysteresis and touch toggle, duty clamp.
module bhsq_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  input  bhsq_pkg::avg_t       data_i,
  output logic                 pop_o,
  input  bhsq_pkg::avg_t       base_i,
  input  bhsq_pkg::pct_t       pct_i,
  bhsq_out_if.source           result_o
);

  localparam int SB = bhsq_pkg::SAMPLE_BITS;
  localparam int PW = bhsq_pkg::PROD_W;
  localparam int DW = bhsq_pkg::DUTY_PROD_W;

  // Stage A: products
  logic               a_valid_q, a_valid_d;
  logic [PW-1:0]      light_a_q, temp_a_q, touch_a_q;
  bhsq_pkg::lim_t     lim_q;
  logic [SB-1:0]      duty_raw_q;
  logic [SB-1:0]      light_x;
  logic [DW-1:0]      duty_prod;

  // Stage B: state and result register
  logic               out_valid_q, out_valid_d;
  logic               light_st_q, temp_st_q, touch_st_q, held_q;
  logic               light_st_d, temp_st_d, touch_st_d, held_d;
  logic [bhsq_pkg::DUTY_W-1:0] duty_q, duty_d;
  logic               advance, a_take, a_load;
  logic               press, rel, toggle;

  assign advance = !out_valid_q || result_o.ready;
  assign a_take  = a_valid_q && advance;
  assign a_load  = !a_valid_q || advance;
  assign pop_o   = valid_i && a_load;

  assign a_valid_d   = pop_o || (a_valid_q && !a_take);
  assign out_valid_d = a_take || (out_valid_q && !result_o.ready);

  // Light below the floor gives a zero quotient, which clamps to zero.
  always_comb begin
    light_x   = (data_i.light >= SB'(bhsq_pkg::LIGHT_FLOOR))
                ? data_i.light - SB'(bhsq_pkg::LIGHT_FLOOR) : '0;
    duty_prod = DW'(light_x) * DW'(bhsq_pkg::DUTY_MUL);
  end

  // Hysteresis: off wins where both compares hold.
  always_comb begin
    light_st_d = light_st_q;
    temp_st_d  = temp_st_q;
    touch_st_d = touch_st_q;
    held_d     = held_q;
    duty_d     = duty_q;
    press      = (touch_a_q <= lim_q.touch_press);
    rel        = (touch_a_q >= lim_q.touch_release);
    toggle     = press && !held_q;
    if (a_take) begin
      if (light_a_q <= lim_q.light_off) begin
        light_st_d = 1'b0;
      end else if (light_a_q >= lim_q.light_on) begin
        light_st_d = 1'b1;
      end
      if (temp_a_q <= lim_q.temp_off) begin
        temp_st_d = 1'b0;
      end else if (temp_a_q >= lim_q.temp_on) begin
        temp_st_d = 1'b1;
      end
      if (toggle) begin
        touch_st_d = !touch_st_q;
      end
      // Re-arm after a toggle in the same step, so release wins.
      if (rel) begin
        held_d = 1'b0;
      end else if (toggle) begin
        held_d = 1'b1;
      end
      if (duty_raw_q <= SB'(bhsq_pkg::DUTY_LOW)) begin
        duty_d = '0;
      end else if (duty_raw_q >= SB'(bhsq_pkg::DUTY_HIGH)) begin
        duty_d = bhsq_pkg::DUTY_W'(bhsq_pkg::DUTY_MAX);
      end else begin
        duty_d = duty_raw_q[bhsq_pkg::DUTY_W-1:0];
      end
    end
  end

  assign result_o.valid        = out_valid_q;
  assign result_o.light_led    = light_st_q;
  assign result_o.temp_led     = temp_st_q;
  assign result_o.touch_led    = touch_st_q;
  assign result_o.duty_percent = duty_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
      light_st_q  <= 1'b0;
      temp_st_q   <= 1'b0;
      touch_st_q  <= 1'b0;
      held_q      <= 1'b0;
    end else begin
      a_valid_q   <= a_valid_d;
      out_valid_q <= out_valid_d;
      light_st_q  <= light_st_d;
      temp_st_q   <= temp_st_d;
      touch_st_q  <= touch_st_d;
      held_q      <= held_d;
    end
  end

  always_ff @(posedge clk_i) begin
    duty_q <= duty_d;
    if (pop_o) begin
      light_a_q <= PW'(data_i.light) * PW'(bhsq_pkg::PCT_SCALE);
      temp_a_q  <= PW'(data_i.temp)  * PW'(bhsq_pkg::PCT_SCALE);
      touch_a_q <= PW'(data_i.touch) * PW'(bhsq_pkg::PCT_SCALE);
      lim_q.light_on      <= PW'(base_i.light) * PW'(pct_i.light_on);
      lim_q.light_off     <= PW'(base_i.light) * PW'(pct_i.light_off);
      lim_q.temp_on       <= PW'(base_i.temp)  * PW'(pct_i.temp_on);
      lim_q.temp_off      <= PW'(base_i.temp)  * PW'(pct_i.temp_off);
      lim_q.touch_press   <= PW'(base_i.touch) * PW'(pct_i.touch_press);
      lim_q.touch_release <= PW'(base_i.touch) * PW'(pct_i.touch_release);
      duty_raw_q <= duty_prod[bhsq_pkg::DUTY_SHIFT +: SB];
    end
  end

endmodule

// ----- rtl/core/baseline_hysteresis_sensor_qualifier_unit.sv -----
// Top level: baseline hysteresis sensor qualifier (front, queue, back, config).
// Throughput: one conversion transaction per cycle unless stalled; a result every fifth after the baseline block.
// Path: a block's sum is registered when its last conversion is taken; its average then
//   passes through the queue, the product stage and the result register.
// Reset: asynchronous, active low; clears sums, baseline, LED states and queue, and
//   loads the threshold registers with their defaults. No clearing pass is needed.
module baseline_hysteresis_sensor_qualifier_unit (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // configuration port
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [bhsq_pkg::ADDR_W-1:0]        paddr,
  input  logic [bhsq_pkg::APB_DATA_W-1:0]    pwdata,
  output logic [bhsq_pkg::APB_DATA_W-1:0]    prdata,
  output logic                               pready,
  // conversion and result channels
  bhsq_in_if.sink                            sample_i,
  bhsq_out_if.source                         result_o
);

  bhsq_pkg::pct_t   pct;
  bhsq_pkg::avg_t   base;
  bhsq_pkg::avg_t   q_data;
  bhsq_pkg::q_wr_t  q_wr;
  logic             q_full;
  logic             q_valid;
  logic             q_pop;

  // Threshold registers; to be written only while the datapath is idle, which the block itself does not enforce.
  bhsq_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .pct_o   (pct)
  );

  // Front: sum each block, average it, keep the first average as the baseline
  // and drop it; forward every later average into the queue.
  bhsq_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .sample_i (sample_i),
    .full_i   (q_full),
    .wr_o     (q_wr),
    .base_o   (base)
  );

  // Decouple the two halves so either can stall on its own.
  bhsq_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (q_wr),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .data_o  (q_data)
  );

  // Back: exact percent compares against the baseline, touch toggle and duty.
  // The baseline is fixed before the first average reaches the queue.
  bhsq_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (q_valid),
    .data_i   (q_data),
    .pop_o    (q_pop),
    .base_i   (base),
    .pct_i    (pct),
    .result_o (result_o)
  );

endmodule
